// ----- rtl/core/irsp_pkg.sv -----
// ----------------------------------------------------------------------------
// irsp_pkg
// Shared constants, register codes and types of the row shear padder.
// ----------------------------------------------------------------------------
package irsp_pkg;

  localparam int PIX_W      = 32;
  localparam int TAN_W      = 22;
  localparam int DIM_W      = 13;
  localparam int BPP_W      = 3;
  localparam int RUN_W      = 18;
  localparam int PAD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 4096;
  localparam int DEF_TAN_FRAC_BITS = 16;

  localparam logic [TAN_W-1:0] RST_TAN    = '0;
  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(1);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(1);
  localparam logic [BPP_W-1:0] RST_BPP    = BPP_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAN      = 3'd0,
    CFG_WIDTH    = 3'd1,
    CFG_HEIGHT   = 3'd2,
    CFG_TOP_DOWN = 3'd3,
    CFG_BPP      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TAN_W-1:0] tan_q16;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             top_down;
    logic [BPP_W-1:0] bytes_per_pixel;
  } irsp_cfg_t;

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             first;
    logic             ends;
    logic [RUN_W-1:0] shift;
    logic [RUN_W-1:0] blank;
    logic [1:0]       width_lo;
  } irsp_entry_t;

endpackage

// ----- rtl/core/irsp_if.sv -----
// ----------------------------------------------------------------------------
// irsp_if
// Valid/ready channels of the row shear padder: pixels, results, config.
// ----------------------------------------------------------------------------
interface irsp_pix_if;
  import irsp_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface irsp_res_if;
  import irsp_pkg::*;

  logic             valid;
  logic             ready;
  logic             item_kind;
  logic [PIX_W-1:0] pixel_data;
  logic [RUN_W-1:0] run_length;
  logic [PAD_W-1:0] pad_bytes;
  logic             row_end;
  logic             last;

  modport source (output valid, output item_kind, output pixel_data, output run_length,
                  output pad_bytes, output row_end, output last, input ready);
  modport sink   (input valid, input item_kind, input pixel_data, input run_length,
                  input pad_bytes, input row_end, input last, output ready);
endinterface

interface irsp_cfg_if;
  import irsp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/irsp_front.sv -----
// ----------------------------------------------------------------------------
// irsp_front
// Accepts pixels, tracks column and row, forms frame shift and row blank.
// ----------------------------------------------------------------------------
module irsp_front #(
  parameter int MAX_WIDTH     = irsp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = irsp_pkg::DEF_MAX_HEIGHT,
  parameter int TAN_FRAC_BITS = irsp_pkg::DEF_TAN_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  irsp_pkg::irsp_cfg_t   cfg_i,
  irsp_pix_if.sink              in_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output irsp_pkg::irsp_entry_t q_entry_o
);
  import irsp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = HW + TAN_W;

  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [RUN_W-1:0] shift_q, shift_d;
  logic [RUN_W-1:0] blank_q, blank_d;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic             accept, first, ends, row_lt, row_last;
  logic [PW-1:0]    prod_h, prod_b;
  logic [PW-1:0]    scl_h, scl_b;
  logic [RUN_W-1:0] sat_h, sat_b;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_i.image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_i.image_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_i.image_height);
    end
  end

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign first    = (col_q == '0);
  assign ends     = (WW'(col_q) + WW'(1)) >= eff_w;
  assign row_lt   = HW'(row_q) < eff_h;
  assign row_last = (HW'(row_q) + HW'(1)) >= eff_h;

  // scaled blanks, floor(n * tan) with saturation
  assign prod_h = PW'(eff_h) * PW'(cfg_i.tan_q16);
  assign prod_b = PW'(eff_h - HW'(row_q)) * PW'(cfg_i.tan_q16);
  assign scl_h  = prod_h >> TAN_FRAC_BITS;
  assign scl_b  = prod_b >> TAN_FRAC_BITS;
  assign sat_h  = (scl_h > PW'(RUN_MAX)) ? RUN_MAX : scl_h[RUN_W-1:0];
  assign sat_b  = (scl_b > PW'(RUN_MAX)) ? RUN_MAX : scl_b[RUN_W-1:0];

  always_comb begin
    shift_d = shift_q;
    blank_d = blank_q;
    if (first) begin
      if (row_q == '0 || !row_lt) begin
        shift_d = sat_h;
      end
      blank_d = row_lt ? sat_b : '0;
    end
    if (ends) begin
      col_d = '0;
      row_d = row_last ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
  end

  assign q_push_o            = accept;
  assign q_entry_o.pixel     = in_i.pixel_value;
  assign q_entry_o.first     = first;
  assign q_entry_o.ends      = ends;
  assign q_entry_o.shift     = shift_d;
  assign q_entry_o.blank     = blank_d;
  assign q_entry_o.width_lo  = eff_w[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      shift_q <= '0;
      blank_q <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      shift_q <= shift_d;
      blank_q <= blank_d;
    end
  end

endmodule

// ----- rtl/core/irsp_queue.sv -----
// ----------------------------------------------------------------------------
// irsp_queue
// Two-entry queue that decouples pixel intake from result generation.
// ----------------------------------------------------------------------------
module irsp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  irsp_pkg::irsp_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output irsp_pkg::irsp_entry_t entry_o
);
  import irsp_pkg::*;

  localparam int DEPTH = 2;

  irsp_entry_t mem_q [DEPTH];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o  = (count_q == 2'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- rtl/core/irsp_back.sv -----
// ----------------------------------------------------------------------------
// irsp_back
// Expands each queued pixel into lead run, pixel and trail run results.
// ----------------------------------------------------------------------------
module irsp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  irsp_pkg::irsp_cfg_t   cfg_i,
  input  logic                  q_valid_i,
  input  irsp_pkg::irsp_entry_t q_entry_i,
  output logic                  q_pop_o,
  irsp_res_if.source            out_o
);
  import irsp_pkg::*;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_PIX   = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;

  logic [1:0]       ph_q, ph_d, ph_cur;
  logic [RUN_W-1:0] rest, lead, trail;
  logic             has_lead, has_trail, load;
  logic [1:0]       outw_lo, pad_prod;
  logic [PAD_W-1:0] pad;

  logic             valid_q;
  logic             kind_q, kind_d;
  logic [PIX_W-1:0] data_q, data_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [PAD_W-1:0] pad_q, pad_d;
  logic             rend_q, rend_d;
  logic             last_q, last_d;

  assign rest      = (q_entry_i.shift > q_entry_i.blank) ?
                     q_entry_i.shift - q_entry_i.blank : '0;
  assign lead      = cfg_i.top_down ? q_entry_i.blank : rest;
  assign trail     = cfg_i.top_down ? rest : q_entry_i.blank;
  assign has_lead  = q_entry_i.first && (lead != '0);
  assign has_trail = q_entry_i.ends && (trail != '0);

  // row padding only depends on the low two bits
  assign outw_lo  = q_entry_i.shift[1:0] + q_entry_i.width_lo;
  assign pad_prod = 2'(outw_lo * cfg_i.bytes_per_pixel[1:0]);
  assign pad      = 2'b00 - pad_prod;

  assign load   = q_valid_i && (!valid_q || out_o.ready);
  assign ph_cur = (ph_q == PH_LEAD && !has_lead) ? PH_PIX : ph_q;

  always_comb begin
    ph_d    = ph_q;
    q_pop_o = 1'b0;
    kind_d  = 1'b0;
    data_d  = '0;
    run_d   = '0;
    pad_d   = '0;
    rend_d  = 1'b0;
    last_d  = 1'b0;
    unique case (ph_cur)
      PH_LEAD: begin
        kind_d = 1'b1;
        run_d  = lead;
        ph_d   = PH_PIX;
      end
      PH_PIX: begin
        data_d = q_entry_i.pixel;
        if (has_trail) begin
          ph_d = PH_TRAIL;
        end else begin
          rend_d  = q_entry_i.ends;
          pad_d   = q_entry_i.ends ? pad : '0;
          last_d  = 1'b1;
          q_pop_o = load;
          ph_d    = PH_LEAD;
        end
      end
      PH_TRAIL: begin
        kind_d  = 1'b1;
        run_d   = trail;
        pad_d   = pad;
        rend_d  = 1'b1;
        last_d  = 1'b1;
        q_pop_o = load;
        ph_d    = PH_LEAD;
      end
      default: begin
        ph_d = PH_LEAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_LEAD;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        ph_q    <= ph_d;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      data_q <= data_d;
      run_q  <= run_d;
      pad_q  <= pad_d;
      rend_q <= rend_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.item_kind  = kind_q;
  assign out_o.pixel_data = data_q;
  assign out_o.run_length = run_q;
  assign out_o.pad_bytes  = pad_q;
  assign out_o.row_end    = rend_q;
  assign out_o.last       = last_q;

endmodule

// ----- rtl/core/image_row_shear_padder_unit.sv -----
// ----------------------------------------------------------------------------
// image_row_shear_padder_unit
// Path: a transferred pixel is written into the two-entry queue, and its first
// result is loaded from the queue head into the output register.
// Output: one result per cycle through the output register while out_o.ready
// holds; a pixel inside a row gives one result, a row's first or last pixel up to three.
// Reset: column/row counters cleared, queue empty, registers to defaults.
// ----------------------------------------------------------------------------
module image_row_shear_padder_unit #(
  parameter int MAX_WIDTH     = irsp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = irsp_pkg::DEF_MAX_HEIGHT,
  parameter int TAN_FRAC_BITS = irsp_pkg::DEF_TAN_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  irsp_cfg_if.sink    cfg_i,
  irsp_pix_if.sink    in_i,
  irsp_res_if.source  out_o
);
  import irsp_pkg::*;

  irsp_cfg_t   cfg_q;
  logic        q_push, q_full, q_pop, q_valid;
  irsp_entry_t push_entry, head_entry;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tan_q16         <= RST_TAN;
      cfg_q.image_width     <= RST_WIDTH;
      cfg_q.image_height    <= RST_HEIGHT;
      cfg_q.top_down        <= 1'b0;
      cfg_q.bytes_per_pixel <= RST_BPP;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_TAN:      cfg_q.tan_q16         <= cfg_i.data[TAN_W-1:0];
        CFG_WIDTH:    cfg_q.image_width     <= cfg_i.data[DIM_W-1:0];
        CFG_HEIGHT:   cfg_q.image_height    <= cfg_i.data[DIM_W-1:0];
        CFG_TOP_DOWN: cfg_q.top_down        <= cfg_i.data[0];
        CFG_BPP:      cfg_q.bytes_per_pixel <= cfg_i.data[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  irsp_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .TAN_FRAC_BITS(TAN_FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_entry_o(push_entry)
  );

  irsp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  irsp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(q_valid),
    .q_entry_i(head_entry),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );

endmodule

// ----- rtl/core/irsp_checker.sv -----
// ----------------------------------------------------------------------------
// irsp_checker
// Port-level checks on the result stream of the row shear padder.
// ----------------------------------------------------------------------------
module irsp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       item_kind_i,
  input logic [irsp_pkg::PIX_W-1:0] pixel_data_i,
  input logic [irsp_pkg::RUN_W-1:0] run_length_i,
  input logic [irsp_pkg::PAD_W-1:0] pad_bytes_i,
  input logic                       row_end_i,
  input logic                       last_i
);
  import irsp_pkg::*;

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(item_kind_i)
      && $stable(pixel_data_i) && $stable(run_length_i) && $stable(last_i))
    else $error("result changed while stalled");

  // runs are never empty and carry no pixel
  a_run_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && item_kind_i |-> run_length_i != '0 && pixel_data_i == '0)
    else $error("malformed run result");

  // padding only at a row end
  a_pad_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !row_end_i |-> pad_bytes_i == '0)
    else $error("padding outside row end");

  // a row end closes the results of its pixel
  a_rend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && row_end_i |-> last_i)
    else $error("row end without last");

endmodule

bind image_row_shear_padder_unit irsp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .item_kind_i (out_o.item_kind),
  .pixel_data_i(out_o.pixel_data),
  .run_length_i(out_o.run_length),
  .pad_bytes_i (out_o.pad_bytes),
  .row_end_i   (out_o.row_end),
  .last_i      (out_o.last)
);
